>>> sv/twacc_pkg.sv
// Shared constants and types for the time window access table.
package twacc_pkg;

  localparam int MaxWindows = 8;
  localparam int MinW       = 11;
  localparam int CntW       = $clog2(MaxWindows + 1);
  localparam int IdxW       = (MaxWindows > 1) ? $clog2(MaxWindows) : 1;
  localparam int KindW      = 2;
  localparam int VerdictW   = 2;
  localparam int EntryCntW  = 4;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 8;

  localparam logic [KindW-1:0] KindInsert = 2'd0;
  localparam logic [KindW-1:0] KindQuery  = 2'd1;
  localparam logic [KindW-1:0] KindClear  = 2'd2;

  localparam logic [VerdictW-1:0] VerdictUnlimited = 2'd0;
  localparam logic [VerdictW-1:0] VerdictAllowed   = 2'd1;
  localparam logic [VerdictW-1:0] VerdictDenied    = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_RESP = 3'b100
  } state_t;

endpackage

>>> sv/time_window_access_table_top.sv
// Time window access table: window store, scan sequencer and result register.
//
// Holds up to MaxWindows minute-of-day windows and takes three kinds of item:
// insert a window, query a minute, clear the table. Each item gives exactly one
// result carrying the accepted flag, the verdict and the entry count after the
// item. An insert or query that finds a non-empty table scans the stored
// windows one per cycle through a single compare unit fed by a registered read
// of the window store, stopping at the first hit. Clear, an empty table, a
// malformed window and the unused kind skip the scan. One item is in work at a
// time; s_tready is high only while the sequencer is idle, and the result
// register lets the next item in while a result waits for m_tready.
module time_window_access_table_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [10:0] range_start, [21:11] range_end, [32:22] now_minute, [39:33] zero
  input  logic [twacc_pkg::InDataW-1:0]    s_tdata,
  // [1:0] kind
  input  logic [twacc_pkg::KindW-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [0] accepted, [2:1] verdict, [6:3] entry_count, [7] zero
  output logic [twacc_pkg::OutDataW-1:0]   m_tdata
);
  import twacc_pkg::*;

  state_t state;

  logic [MinW-1:0]     starts [MaxWindows];
  logic [MinW-1:0]     ends   [MaxWindows];
  logic [MinW-1:0]     rd_start;
  logic [MinW-1:0]     rd_end;

  logic [CntW-1:0]     count;
  logic [CntW-1:0]     addr_idx;
  logic [CntW-1:0]     cmp_idx;
  logic                cmp_valid;

  logic [KindW-1:0]    op_kind;
  logic [MinW-1:0]     op_start;
  logic [MinW-1:0]     op_end;
  logic [MinW-1:0]     op_now;

  logic                res_acc;
  logic [VerdictW-1:0] res_verdict;

  logic [MinW-1:0]     in_start;
  logic [MinW-1:0]     in_end;
  logic [MinW-1:0]     in_now;
  logic                in_accept;

  logic                new_covers;
  logic                old_covers;
  logic                now_hit;
  logic [CntW:0]       cmp_next;
  logic                cmp_last;
  logic                has_room;

  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic [MinW-1:0]     wr_start;
  logic [MinW-1:0]     wr_end;

  logic                out_free;
  logic [CntW+EntryCntW-1:0] cnt_ext;

  assign in_start  = s_tdata[MinW-1:0];
  assign in_end    = s_tdata[2*MinW-1:MinW];
  assign in_now    = s_tdata[3*MinW-1:2*MinW];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign has_room  = (count < CntW'(MaxWindows));

  // shared compare unit, fed by the registered read of the store
  assign new_covers = (rd_start >= op_start) && (rd_end <= op_end);
  assign old_covers = (op_start >= rd_start) && (op_end <= rd_end);
  assign now_hit    = (op_now >= rd_start) && (op_now < rd_end);
  assign cmp_next   = {1'b0, cmp_idx} + {{CntW{1'b0}}, 1'b1};
  assign cmp_last   = (cmp_next == {1'b0, count});

  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = count[IdxW-1:0];
    wr_start = op_start;
    wr_end   = op_end;
    if (state == ST_IDLE) begin
      wr_start = in_start;
      wr_end   = in_end;
      // first window into an empty table
      if (in_accept && s_tuser == KindInsert && in_start < in_end && count == '0) begin
        wr_en = 1'b1;
      end
    end else if (state == ST_SCAN && cmp_valid && op_kind == KindInsert) begin
      if (new_covers) begin
        wr_en   = 1'b1;
        wr_addr = cmp_idx[IdxW-1:0];
      end else if (!old_covers && cmp_last && has_room) begin
        wr_en = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      starts[wr_addr] <= wr_start;
      ends[wr_addr]   <= wr_end;
    end
    rd_start <= starts[addr_idx[IdxW-1:0]];
    rd_end   <= ends[addr_idx[IdxW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            op_kind     <= s_tuser;
            op_start    <= in_start;
            op_end      <= in_end;
            op_now      <= in_now;
            res_acc     <= 1'b0;
            res_verdict <= VerdictUnlimited;
            addr_idx    <= '0;
            cmp_valid   <= 1'b0;
            state       <= ST_RESP;
            if (s_tuser == KindClear) begin
              count <= '0;
            end else if (s_tuser == KindInsert && in_start < in_end) begin
              if (count == '0) begin
                count   <= {{(CntW-1){1'b0}}, 1'b1};
                res_acc <= 1'b1;
              end else begin
                state <= ST_SCAN;
              end
            end else if (s_tuser == KindQuery && count != '0) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          // issue the next read while the previous entry is compared
          addr_idx  <= addr_idx + {{(CntW-1){1'b0}}, 1'b1};
          cmp_idx   <= addr_idx;
          cmp_valid <= (addr_idx < count);
          if (cmp_valid) begin
            if (op_kind == KindInsert) begin
              if (new_covers || old_covers) begin
                res_acc <= 1'b1;
                state   <= ST_RESP;
              end else if (cmp_last) begin
                if (has_room) begin
                  count   <= count + {{(CntW-1){1'b0}}, 1'b1};
                  res_acc <= 1'b1;
                end
                state <= ST_RESP;
              end
            end else begin
              if (now_hit) begin
                res_verdict <= VerdictAllowed;
                state       <= ST_RESP;
              end else if (cmp_last) begin
                res_verdict <= VerdictDenied;
                state       <= ST_RESP;
              end
            end
          end
        end
        ST_RESP: begin
          cmp_valid <= 1'b0;
          if (out_free) begin
            m_tdata  <= {1'b0, cnt_ext[EntryCntW-1:0], res_verdict, res_acc};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // drop the result once taken, unless a new one is loaded
      if (m_tvalid && m_tready && !(state == ST_RESP)) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign cnt_ext = {{EntryCntW{1'b0}}, count};

endmodule

>>> test/time_window_access_table_top_test.sv
// Self-checking testbench for the time window access table: stream driver, monitor, predictor.
module time_window_access_table_top_test;
  import twacc_pkg::*;

  localparam logic [KindW-1:0] KindUnused = 2'd3;
  localparam int CycleLimit   = 500000;
  localparam int RandomItems  = 900;
  localparam int ShadowDepth  = 16;

  typedef logic [MinW-1:0] minute_t;

  typedef struct {
    logic [KindW-1:0] kind;
    minute_t          lo;
    minute_t          hi;
    minute_t          now;
    bit               drain;   // hold until every answer is back
  } request_t;

  typedef struct {
    logic                 accepted;
    logic [VerdictW-1:0]  verdict;
    logic [EntryCntW-1:0] count;
  } answer_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [KindW-1:0]    s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  time_window_access_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t requests_todo[$];
  answer_t  answers_due[$];
  int       n_sent = 0;
  int       n_seen = 0;
  int       errors = 0;
  int       cycles = 0;

  // Predicted table contents
  minute_t  win_lo[MaxWindows];
  minute_t  win_hi[MaxWindows];
  int       held = 0;

  int n_append = 0, n_overwrite = 0, n_covered = 0, n_refused = 0, n_malformed = 0;
  int n_allowed = 0, n_denied = 0, n_unlimited = 0, n_clear = 0, n_unused = 0;
  int peak_held = 0;

  // Windows issued since the last clear, used to aim inserts and queries at edges
  int shadow_lo[ShadowDepth];
  int shadow_hi[ShadowDepth];
  int shadow_n = 0;

  task automatic table_apply(input request_t r, output answer_t a);
    int  i;
    bit  done;
    a.accepted = 1'b0;
    a.verdict  = VerdictUnlimited;
    done = 0;
    case (r.kind)
      KindInsert: begin
        if (r.lo >= r.hi) begin
          n_malformed++;
        end else begin
          for (i = 0; i < held && !done; i++) begin
            if (win_lo[i] >= r.lo && win_hi[i] <= r.hi) begin
              win_lo[i] = r.lo;
              win_hi[i] = r.hi;
              n_overwrite++;
              done = 1;
            end else if (r.lo >= win_lo[i] && r.hi <= win_hi[i]) begin
              n_covered++;
              done = 1;
            end
          end
          if (!done && held < MaxWindows) begin
            win_lo[held] = r.lo;
            win_hi[held] = r.hi;
            held++;
            n_append++;
            done = 1;
          end else if (!done) begin
            n_refused++;
          end
          a.accepted = done;
        end
      end
      KindQuery: begin
        if (held == 0) begin
          n_unlimited++;
        end else begin
          a.verdict = VerdictDenied;
          for (i = 0; i < held; i++)
            if (r.now >= win_lo[i] && r.now < win_hi[i]) a.verdict = VerdictAllowed;
          if (a.verdict == VerdictAllowed) n_allowed++;
          else n_denied++;
        end
      end
      KindClear: begin
        held = 0;
        n_clear++;
      end
      default: n_unused++;
    endcase
    if (held > peak_held) peak_held = held;
    a.count = EntryCntW'(held);
  endtask

  function automatic request_t mk(logic [KindW-1:0] kind, int lo, int hi, int now,
                                  bit drain = 0);
    request_t r;
    r.kind  = kind;
    r.lo    = minute_t'(lo);
    r.hi    = minute_t'(hi);
    r.now   = minute_t'(now);
    r.drain = drain;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int pick, k, idx, lo, hi;
    r.kind  = KindQuery;
    r.lo    = minute_t'($urandom);
    r.hi    = minute_t'($urandom);
    r.now   = minute_t'($urandom);
    r.drain = ($urandom_range(0, 59) == 0);
    pick = $urandom_range(0, 99);
    k    = $urandom_range(0, 9);
    if (pick < 4) begin
      r.kind   = KindClear;
      shadow_n = 0;
    end else if (pick < 6) begin
      r.kind = KindUnused;
    end else if (pick < 50) begin
      r.kind = KindInsert;
      if (k < 3 && shadow_n > 0) begin
        idx = $urandom_range(0, shadow_n - 1);
        lo  = shadow_lo[idx];
        hi  = shadow_hi[idx];
        if ($urandom_range(0, 1)) begin
          // shrink inside an earlier window
          lo = lo + $urandom_range(0, hi - lo - 1);
          hi = $urandom_range(lo + 1, hi);
        end else begin
          // widen around an earlier window
          lo = lo - $urandom_range(0, lo);
          hi = hi + $urandom_range(0, 1440 - hi);
        end
      end else if (k == 3) begin
        lo = $urandom_range(0, 2047);
        hi = $urandom_range(0, 2047);
      end else begin
        lo = $urandom_range(0, 1439);
        hi = lo + $urandom_range(1, (k < 6) ? 30 : 300);
        if (hi > 1440) hi = 1440;
      end
      r.lo = minute_t'(lo);
      r.hi = minute_t'(hi);
      if (lo < hi && hi <= 1440) begin
        if (shadow_n < ShadowDepth) begin
          idx = shadow_n;
          shadow_n++;
        end else begin
          idx = $urandom_range(0, ShadowDepth - 1);
        end
        shadow_lo[idx] = lo;
        shadow_hi[idx] = hi;
      end
    end else begin
      if (k < 5 && shadow_n > 0) begin
        idx = $urandom_range(0, shadow_n - 1);
        case ($urandom_range(0, 3))
          0: r.now = minute_t'(shadow_lo[idx] - 1);
          1: r.now = minute_t'(shadow_lo[idx]);
          2: r.now = minute_t'(shadow_hi[idx] - 1);
          default: r.now = minute_t'(shadow_hi[idx]);
        endcase
      end else if (k != 5) begin
        r.now = minute_t'($urandom_range(0, 1439));
      end
    end
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps
  int       burst_left = 1;
  int       gap_left = 0;
  bit       tx_hs, tx_show;
  answer_t  tx_answer;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      tx_hs = s_tvalid && s_tready;
      if (tx_hs) begin
        table_apply(requests_todo.pop_front(), tx_answer);
        answers_due.push_back(tx_answer);
        n_sent <= n_sent + 1;
      end
      tx_show = s_tvalid && !tx_hs;
      if (!tx_show) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests_todo.size() > 0 &&
                     (!requests_todo[0].drain || (!tx_hs && n_sent == n_seen))) begin
          tx_show = 1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_tvalid <= tx_show;
      if (tx_show) begin
        s_tdata <= {{(InDataW - 3 * MinW){1'b0}}, requests_todo[0].now,
                    requests_todo[0].hi, requests_todo[0].lo};
        s_tuser <= requests_todo[0].kind;
      end
    end
  end

  // Receiver: stall pattern that changes mode every so often
  int rx_mode = 0;
  int rx_left = 0;
  int rx_phase = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode  = $urandom_range(0, 3);
        rx_left  = $urandom_range(30, 250);
        rx_phase = 0;
      end else begin
        rx_left--;
      end
      rx_phase++;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        2: m_tready <= ($urandom_range(0, 4) == 0);
        default: m_tready <= (rx_phase % 16) < 9;
      endcase
    end
  end

  function automatic bit field_matches(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 0;
    end
    return 1;
  endfunction

  answer_t  rx_want;
  bit       rx_ok;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        rx_want = answers_due.pop_front();
        rx_ok = field_matches("accepted", int'(rx_want.accepted), int'(m_tdata[0])) &
                field_matches("verdict", int'(rx_want.verdict), int'(m_tdata[2:1])) &
                field_matches("entry_count", int'(rx_want.count), int'(m_tdata[6:3]));
        if (!rx_ok) errors++;
      end
      n_seen <= n_seen + 1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycles, answers_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  int counted;
  request_t gen;

  initial begin
    // Directed: empty table, malformed windows, extremes, cover and overwrite, full table
    requests_todo.push_back(mk(KindQuery, 0, 0, 700));
    requests_todo.push_back(mk(KindInsert, 100, 100, 0));
    requests_todo.push_back(mk(KindInsert, 1439, 1, 0));
    requests_todo.push_back(mk(KindInsert, 0, 1, 0));
    requests_todo.push_back(mk(KindInsert, 1439, 1440, 0));
    requests_todo.push_back(mk(KindQuery, 0, 0, 0));
    requests_todo.push_back(mk(KindQuery, 0, 0, 1440));
    requests_todo.push_back(mk(KindInsert, 600, 660, 0));
    requests_todo.push_back(mk(KindInsert, 610, 620, 0));
    requests_todo.push_back(mk(KindInsert, 500, 700, 0));
    requests_todo.push_back(mk(KindInsert, 100, 110, 0));
    requests_todo.push_back(mk(KindInsert, 200, 210, 0));
    requests_todo.push_back(mk(KindInsert, 300, 310, 0));
    requests_todo.push_back(mk(KindInsert, 400, 410, 0));
    requests_todo.push_back(mk(KindInsert, 800, 810, 0));
    requests_todo.push_back(mk(KindInsert, 900, 910, 0, 1));
    requests_todo.push_back(mk(KindInsert, 1439, 1440, 0));
    requests_todo.push_back(mk(KindInsert, 95, 115, 0));
    requests_todo.push_back(mk(KindInsert, 1500, 2047, 0));
    requests_todo.push_back(mk(KindQuery, 0, 0, 2047));
    requests_todo.push_back(mk(KindQuery, 0, 0, 1439));
    requests_todo.push_back(mk(KindUnused, 2047, 2047, 2047));
    requests_todo.push_back(mk(KindClear, 2047, 2047, 2047));
    requests_todo.push_back(mk(KindInsert, 2000, 2047, 0));
    requests_todo.push_back(mk(KindQuery, 0, 0, 2046));
    requests_todo.push_back(mk(KindClear, 0, 0, 0));

    // Random: ignored items (unused kind, malformed window) do not count
    counted = 0;
    while (counted < RandomItems) begin
      gen = random_request();
      requests_todo.push_back(gen);
      if (!(gen.kind == KindUnused || (gen.kind == KindInsert && gen.lo >= gen.hi)))
        counted++;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (requests_todo.size() != 0 || n_sent != n_seen);
    repeat (30) @(posedge clk);

    if (answers_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, answers_due.size());
      errors++;
    end
    $display("Inserts: %0d appended, %0d overwrote, %0d already held, %0d refused, %0d malformed",
             n_append, n_overwrite, n_covered, n_refused, n_malformed);
    $display("Queries: %0d allowed, %0d denied, %0d unlimited; %0d clears, %0d unused, peak %0d",
             n_allowed, n_denied, n_unlimited, n_clear, n_unused, peak_held);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
